FILE: rtl/core/assert_macros.svh
// Assertion macros used by the top level of the price histogram accumulator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define PHIST_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define PHIST_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

FILE: rtl/core/phist_pkg.sv
// Shared types, widths and codes of the price histogram accumulator.
package phist_pkg;

    localparam int MAX_BUCKETS = 64;
    localparam int ADDR_W      = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
    localparam int CNT_W       = $clog2(MAX_BUCKETS + 1);

    localparam int PRICE_W     = 40;
    localparam int QTY_W       = 48;
    localparam int TOTAL_W     = 56;
    localparam int BCNT_W      = 7;
    localparam int CMD_W       = 2;
    localparam int STATUS_W    = 3;
    localparam int IDX_OUT_W   = 6;
    localparam int CFG_IDX_W   = 2;
    localparam int DIV_CNT_W   = $clog2(PRICE_W + 1);

    localparam logic [PRICE_W-1:0] LOW_RESET   = PRICE_W'(0);
    localparam logic [PRICE_W-1:0] HIGH_RESET  = PRICE_W'(6400);
    localparam logic [BCNT_W-1:0]  COUNT_RESET = BCNT_W'(64);

    localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;

    localparam logic [CFG_IDX_W-1:0] CFG_LOWEST  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HIGHEST = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COUNT   = 2'd2;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK         = 3'd0,
        STAT_RANGE      = 3'd1,
        STAT_ZERO_WIDTH = 3'd2,
        STAT_UNDERFLOW  = 3'd3,
        STAT_OVERFLOW   = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIVW,
        S_DIVI,
        S_READ,
        S_MOD,
        S_SCAN,
        S_DONE
    } state_t;

endpackage

FILE: rtl/core/phist_ram.sv
// Generic single-write, single-read RAM with registered read data.
module phist_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                      clk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic                                      re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: rtl/core/phist_div.sv
// Restoring divider for price words, one quotient bit per cycle.
module phist_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [phist_pkg::PRICE_W-1:0] dividend,
    input  logic [phist_pkg::PRICE_W-1:0] divisor,
    output logic                          done,
    output logic [phist_pkg::PRICE_W-1:0] quotient
);

    import phist_pkg::*;

    logic [PRICE_W-1:0]   rem_reg;
    logic [PRICE_W-1:0]   quo_reg;
    logic [PRICE_W-1:0]   dvs_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;

    logic [PRICE_W:0]     shifted;
    logic [PRICE_W:0]     diff;
    logic                 fits;
    logic [PRICE_W-1:0]   rem_next;
    logic [PRICE_W-1:0]   quo_next;

    always_comb
    begin
        shifted  = {rem_reg, quo_reg[PRICE_W-1]};
        diff     = shifted - {1'b0, dvs_reg};
        fits     = !diff[PRICE_W];
        rem_next = fits ? diff[PRICE_W-1:0] : shifted[PRICE_W-1:0];
        quo_next = {quo_reg[PRICE_W-2:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= DIV_CNT_W'(PRICE_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - DIV_CNT_W'(1);
                if (cnt_reg == DIV_CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

FILE: rtl/core/price_histogram_accumulator.sv
// Top level of the price histogram accumulator: sequencer, state and output register.
// One item is worked at a time. An item flagged for range or a zero bucket count
// goes straight to the done state; otherwise a bit-per-cycle divider finds the bucket
// width and, if that is not zero, the bucket index, followed by a read of the bucket
// memory and a write-back for an add or remove that neither overflows nor underflows.
// A successful remove then sweeps all MAX_BUCKETS entries through the memory read port
// to find the new largest bucket. A new item is taken as soon as the previous one has
// been placed in the output register, even while that result still waits on out_stall.
// Bucket entries come out of reset as zero through per-entry valid bits, so no clearing
// pass is needed. Configuration is to be written only while idle; the block itself
// does not enforce this.
`include "assert_macros.svh"

module price_histogram_accumulator (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write,
    input  logic [phist_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [phist_pkg::PRICE_W-1:0]   cfg_data,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [phist_pkg::CMD_W-1:0]     command,
    input  logic [phist_pkg::PRICE_W-1:0]   price,
    input  logic [phist_pkg::QTY_W-1:0]     quantity,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [phist_pkg::STATUS_W-1:0]  status,
    output logic [phist_pkg::IDX_OUT_W-1:0] bin_index,
    output logic [phist_pkg::QTY_W-1:0]     bucket_quantity,
    output logic [phist_pkg::TOTAL_W-1:0]   total_quantity,
    output logic [phist_pkg::QTY_W-1:0]     largest_quantity
);

    import phist_pkg::*;

    state_t               state_reg;
    state_t               state_next;

    logic [PRICE_W-1:0]   low_reg;
    logic [PRICE_W-1:0]   high_reg;
    logic [BCNT_W-1:0]    bcount_reg;

    logic [CMD_W-1:0]     cmd_reg;
    logic [PRICE_W-1:0]   price_reg;
    logic [QTY_W-1:0]     qty_reg;
    logic [ADDR_W-1:0]    idx_reg;
    status_t              res_status_reg;
    logic [QTY_W-1:0]     res_bq_reg;

    logic [TOTAL_W-1:0]   total_reg;
    logic [QTY_W-1:0]     largest_reg;
    logic [MAX_BUCKETS-1:0] valid_reg;
    logic                 rd_valid_reg;
    logic [CNT_W-1:0]     scan_cnt_reg;

    logic                 out_valid_reg;
    logic [STATUS_W-1:0]  out_status_reg;
    logic [IDX_OUT_W-1:0] out_idx_reg;
    logic [QTY_W-1:0]     out_bq_reg;
    logic [TOTAL_W-1:0]   out_total_reg;
    logic [QTY_W-1:0]     out_largest_reg;

    logic [CNT_W-1:0]     cnt_eff;
    logic                 in_range;
    logic                 accept_in;
    logic                 out_free;
    logic                 capture;
    logic                 is_add;
    logic                 is_rem;
    logic [QTY_W-1:0]     bq_cur;
    logic [QTY_W:0]       add_sum;
    logic [TOTAL_W:0]     tot_sum;
    logic                 ovf;
    logic                 unf;
    logic                 quo_big;
    logic [ADDR_W-1:0]    idx_calc;
    logic                 scan_end;
    logic                 done_ok;

    logic                 div_start;
    logic [PRICE_W-1:0]   div_dividend;
    logic [PRICE_W-1:0]   div_divisor;
    logic                 div_done;
    logic [PRICE_W-1:0]   div_quo;

    logic                 ram_we;
    logic [QTY_W-1:0]     ram_wdata;
    logic                 ram_re;
    logic [ADDR_W-1:0]    ram_raddr;
    logic [QTY_W-1:0]     ram_rdata;

    phist_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quo)
    );

    phist_ram #(
        .WIDTH (QTY_W),
        .DEPTH (MAX_BUCKETS)
    ) u_bucket_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (idx_reg),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        if (int'(bcount_reg) > MAX_BUCKETS)
        begin
            cnt_eff = CNT_W'(MAX_BUCKETS);
        end
        else
        begin
            cnt_eff = CNT_W'(bcount_reg);
        end
    end

    assign in_range  = (price >= low_reg) && (price <= high_reg);
    assign accept_in = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign is_add    = (cmd_reg == CMD_ADD);
    assign is_rem    = (cmd_reg == CMD_REMOVE);

    // Entries never written read as zero.
    assign bq_cur  = ram_rdata & {QTY_W{rd_valid_reg}};
    assign add_sum = {1'b0, bq_cur} + {1'b0, qty_reg};
    assign tot_sum = {1'b0, total_reg} + (TOTAL_W + 1)'(qty_reg);
    assign ovf     = add_sum[QTY_W] || tot_sum[TOTAL_W];
    assign unf     = (qty_reg > bq_cur);

    // Clamp the quotient to the last bucket in use.
    assign quo_big  = (div_quo >= PRICE_W'(cnt_eff));
    assign idx_calc = quo_big ? ADDR_W'(cnt_eff - CNT_W'(1)) : div_quo[ADDR_W-1:0];
    assign scan_end = (scan_cnt_reg == CNT_W'(MAX_BUCKETS));
    assign done_ok  = (state_reg == S_DONE) && (res_status_reg == STAT_OK);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept_in)
                begin
                    if (!in_range || (cnt_eff == '0))
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_DIVW;
                    end
                end
            end
            S_DIVW:
            begin
                if (div_done)
                begin
                    state_next = (div_quo == '0) ? S_DONE : S_DIVI;
                end
            end
            S_DIVI:
            begin
                if (div_done)
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                state_next = S_MOD;
            end
            S_MOD:
            begin
                state_next = (is_rem && !unf) ? S_SCAN : S_DONE;
            end
            S_SCAN:
            begin
                if (scan_end)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_stall     = 1'b1;
        div_start    = 1'b0;
        div_dividend = '0;
        div_divisor  = '0;
        ram_re       = 1'b0;
        ram_raddr    = idx_reg;
        ram_we       = 1'b0;
        ram_wdata    = is_add ? add_sum[QTY_W-1:0] : (bq_cur - qty_reg);
        capture      = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_stall     = 1'b0;
                div_start    = accept_in && in_range && (cnt_eff != '0);
                div_dividend = high_reg - low_reg;
                div_divisor  = PRICE_W'(cnt_eff);
            end
            S_DIVW:
            begin
                div_start    = div_done && (div_quo != '0);
                div_dividend = price_reg - low_reg;
                div_divisor  = div_quo;
            end
            S_DIVI:
            begin
            end
            S_READ:
            begin
                ram_re = 1'b1;
            end
            S_MOD:
            begin
                ram_we = (is_add && !ovf) || (is_rem && !unf);
            end
            S_SCAN:
            begin
                ram_re    = !scan_end;
                ram_raddr = scan_cnt_reg[ADDR_W-1:0];
            end
            S_DONE:
            begin
                capture = out_free;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            low_reg       <= LOW_RESET;
            high_reg      <= HIGH_RESET;
            bcount_reg    <= COUNT_RESET;
            total_reg     <= '0;
            largest_reg   <= '0;
            valid_reg     <= '0;
            rd_valid_reg  <= 1'b0;
            scan_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= capture || (out_valid_reg && out_stall);

            if (cfg_write)
            begin
                unique case (cfg_index)
                    CFG_LOWEST:  low_reg    <= cfg_data;
                    CFG_HIGHEST: high_reg   <= cfg_data;
                    CFG_COUNT:   bcount_reg <= cfg_data[BCNT_W-1:0];
                    default:
                    begin
                    end
                endcase
            end

            if (ram_re)
            begin
                rd_valid_reg <= valid_reg[ram_raddr];
            end

            if (ram_we)
            begin
                valid_reg[idx_reg] <= 1'b1;
                if (is_add)
                begin
                    total_reg <= tot_sum[TOTAL_W-1:0];
                    if (add_sum[QTY_W-1:0] > largest_reg)
                    begin
                        largest_reg <= add_sum[QTY_W-1:0];
                    end
                end
                else
                begin
                    total_reg   <= total_reg - TOTAL_W'(qty_reg);
                    // Rebuild the maximum from scratch during the sweep.
                    largest_reg <= '0;
                end
            end

            if (state_reg == S_MOD)
            begin
                scan_cnt_reg <= '0;
            end
            else if (state_reg == S_SCAN)
            begin
                if (!scan_end)
                begin
                    scan_cnt_reg <= scan_cnt_reg + CNT_W'(1);
                end
                // Read data is registered, so it belongs to the previous address.
                if ((scan_cnt_reg != '0) && (bq_cur > largest_reg))
                begin
                    largest_reg <= bq_cur;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == S_IDLE) && accept_in)
        begin
            cmd_reg    <= command;
            price_reg  <= price;
            qty_reg    <= quantity;
            idx_reg    <= '0;
            res_bq_reg <= '0;
            if (!in_range)
            begin
                res_status_reg <= STAT_RANGE;
            end
            else if (cnt_eff == '0)
            begin
                res_status_reg <= STAT_ZERO_WIDTH;
            end
            else
            begin
                res_status_reg <= STAT_OK;
            end
        end

        if ((state_reg == S_DIVW) && div_done && (div_quo == '0))
        begin
            res_status_reg <= STAT_ZERO_WIDTH;
        end

        if ((state_reg == S_DIVI) && div_done)
        begin
            idx_reg <= idx_calc;
        end

        if (state_reg == S_MOD)
        begin
            res_bq_reg <= ram_we ? ram_wdata : bq_cur;
            if (is_add && ovf)
            begin
                res_status_reg <= STAT_OVERFLOW;
            end
            else if (is_rem && unf)
            begin
                res_status_reg <= STAT_UNDERFLOW;
            end
        end

        if (capture)
        begin
            out_status_reg  <= res_status_reg;
            out_idx_reg     <= IDX_OUT_W'(idx_reg);
            out_bq_reg      <= res_bq_reg;
            out_total_reg   <= total_reg;
            out_largest_reg <= largest_reg;
        end
    end

    assign out_valid        = out_valid_reg;
    assign status           = out_status_reg;
    assign bin_index        = out_idx_reg;
    assign bucket_quantity  = out_bq_reg;
    assign total_quantity   = out_total_reg;
    assign largest_quantity = out_largest_reg;

    `PHIST_ASSERT_NEXT(a_total_only_in_mod, state_reg != S_MOD, $stable(total_reg))
    `PHIST_ASSERT_IMPL(a_div_done_owned, div_done, state_reg == S_DIVW || state_reg == S_DIVI)
    `PHIST_ASSERT_IMPL(a_idx_in_use, state_reg == S_READ, CNT_W'(idx_reg) < cnt_eff)
    `PHIST_ASSERT_IMPL(a_largest_bound, done_ok, largest_reg >= res_bq_reg)

endmodule
